@@ rtl/core/mh2b_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh2b_pkg
// Shared constants and types for the MurmurHash2 key hasher with bucket
// reduction.
// ----------------------------------------------------------------------------
package mh2b_pkg;

    localparam logic [31:0] C_HASH_SEED  = 32'd5381;
    localparam logic [31:0] C_HASH_MULT  = 32'h5bd1e995;
    localparam int unsigned C_WORD_SHIFT = 24;
    localparam int unsigned C_FIN_SHIFT_A = 13;
    localparam int unsigned C_FIN_SHIFT_B = 15;

    localparam int unsigned C_BCNT_W   = 17;
    localparam logic [C_BCNT_W-1:0] C_BCNT_RESET = 17'd1024;
    localparam int unsigned C_BIDX_W   = 16;
    localparam int unsigned C_DIV_CNT_W = 5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_K1,
        S_MUL_K2,
        S_MUL_H,
        S_MIX_H,
        S_TAIL,
        S_TAIL_WB,
        S_FIN,
        S_FIN_WB,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

@@ rtl/core/mh2b_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh2b_mul
// Shared multiplier: registered low 32 bits of operand times the hash
// multiplier constant.
// ----------------------------------------------------------------------------
module mh2b_mul (
    input  logic        i_clk,
    input  logic [31:0] i_opnd,
    output logic [31:0] o_prod
);
    import mh2b_pkg::*;

    logic [63:0] w_full;
    logic [31:0] r_prod;

    assign w_full = {32'd0, i_opnd} * {32'd0, C_HASH_MULT};

    always_ff @(posedge i_clk) begin
        r_prod <= w_full[31:0];
    end

    assign o_prod = r_prod;

endmodule

@@ rtl/core/mh2b_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh2b_div
// Restoring remainder unit: 32-bit dividend by 17-bit divisor, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module mh2b_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [31:0]               i_dividend,
    input  logic [mh2b_pkg::C_BCNT_W-1:0] i_divisor,
    output mh2b_pkg::t_div_sts        o_sts,
    output logic [mh2b_pkg::C_BCNT_W-1:0] o_rem
);
    import mh2b_pkg::*;

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [C_DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]            r_quo, n_quo;
    logic [C_BCNT_W-1:0]    r_rem, n_rem;
    logic [C_BCNT_W-1:0]    r_div, n_div;

    logic [C_BCNT_W:0] w_sh;
    logic [C_BCNT_W:0] w_diff;
    logic              w_ge;

    assign w_sh   = {r_rem, r_quo[31]};
    assign w_ge   = w_sh >= {1'b0, r_div};
    assign w_diff = w_sh - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '1;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[30:0], w_ge};
            n_rem = w_ge ? w_diff[C_BCNT_W-1:0] : w_sh[C_BCNT_W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_rem      = r_rem;

endmodule

@@ rtl/core/murmur2_key_hash_bucket.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur2_key_hash_bucket
// Streaming MurmurHash2 (32-bit, seed 5381) key hasher with bucket index.
// ----------------------------------------------------------------------------
// Keys arrive one little-endian word per request; the first request carries
// the key length, the last one produces hash_value and the low 16 bits of
// hash_value modulo bucket_count. One request is processed at a time and
// o_ready is high only when idle. All multiplications share one registered
// multiplier and run one after another. The last word then passes through
// the finalize states and the bit-serial remainder unit (skipped, giving 0,
// when bucket_count is zero), after which the result is held until
// taken. bucket_count is written only while idle (o_cfg_ready).
module murmur2_key_hash_bucket (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [31:0]                   i_key_word,
    input  logic [2:0]                    i_valid_bytes,
    input  logic                          i_first_word,
    input  logic                          i_last_word,
    input  logic [15:0]                   i_key_length,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [31:0]                   o_hash_value,
    output logic [mh2b_pkg::C_BIDX_W-1:0] o_bucket_index,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mh2b_pkg::C_BCNT_W-1:0] i_cfg_bucket_count
);
    import mh2b_pkg::*;

    t_state              r_state, n_state;
    logic [C_BCNT_W-1:0] r_bucket_count;
    logic [31:0]         r_word, n_word;
    logic [1:0]          r_nbytes, n_nbytes;
    logic                r_last, n_last;
    logic [31:0]         r_hash, n_hash;
    logic [31:0]         r_k, n_k;
    logic [31:0]         r_hash_out, n_hash_out;
    logic [C_BIDX_W-1:0] r_bucket, n_bucket;

    logic [31:0]         w_opnd;
    logic [31:0]         w_prod;
    logic [31:0]         w_tail_mask;
    logic [31:0]         w_fin;
    logic                w_div_start;
    t_div_sts            w_div_sts;
    logic [C_BCNT_W-1:0] w_div_rem;

    mh2b_mul u_mul (
        .i_clk  (i_clk),
        .i_opnd (w_opnd),
        .o_prod (w_prod)
    );

    mh2b_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_fin),
        .i_divisor  (r_bucket_count),
        .o_sts      (w_div_sts),
        .o_rem      (w_div_rem)
    );

    assign w_fin = w_prod ^ (w_prod >> C_FIN_SHIFT_B);

    always_comb begin
        case (r_nbytes)
            2'd1:    w_tail_mask = 32'h0000_00ff;
            2'd2:    w_tail_mask = 32'h0000_ffff;
            2'd3:    w_tail_mask = 32'h00ff_ffff;
            default: w_tail_mask = 32'h0000_0000;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_word      = r_word;
        n_nbytes    = r_nbytes;
        n_last      = r_last;
        n_hash      = r_hash;
        n_k         = r_k;
        n_hash_out  = r_hash_out;
        n_bucket    = r_bucket;
        w_opnd      = r_hash;
        w_div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_word   = i_key_word;
                    n_nbytes = i_valid_bytes[1:0];
                    n_last   = i_last_word;
                    if (i_first_word) begin
                        n_hash = C_HASH_SEED ^ {16'd0, i_key_length};
                    end
                    if (i_valid_bytes[2]) begin
                        n_state = S_MUL_K1;
                    end else if (i_valid_bytes[1:0] != 2'd0) begin
                        n_state = S_TAIL;
                    end else if (i_last_word) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_MUL_K1: begin
                w_opnd  = r_word;
                n_state = S_MUL_K2;
            end
            S_MUL_K2: begin
                w_opnd  = w_prod ^ (w_prod >> C_WORD_SHIFT);
                n_state = S_MUL_H;
            end
            S_MUL_H: begin
                // hold the mixed key word while h is multiplied
                w_opnd  = r_hash;
                n_k     = w_prod;
                n_state = S_MIX_H;
            end
            S_MIX_H: begin
                n_hash  = w_prod ^ r_k;
                n_state = r_last ? S_FIN : S_IDLE;
            end
            S_TAIL: begin
                w_opnd  = r_hash ^ (r_word & w_tail_mask);
                n_state = S_TAIL_WB;
            end
            S_TAIL_WB: begin
                n_hash  = w_prod;
                n_state = r_last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                w_opnd  = r_hash ^ (r_hash >> C_FIN_SHIFT_A);
                n_state = S_FIN_WB;
            end
            S_FIN_WB: begin
                n_hash_out = w_fin;
                if (r_bucket_count == '0) begin
                    n_bucket = '0;
                    n_state  = S_OUT;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_sts.done) begin
                    n_bucket = w_div_rem[C_BIDX_W-1:0];
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_hash         <= '0;
            r_bucket_count <= C_BCNT_RESET;
        end else begin
            r_state <= n_state;
            r_hash  <= n_hash;
            if (i_cfg_valid && o_cfg_ready) begin
                r_bucket_count <= i_cfg_bucket_count;
            end
        end
        r_word     <= n_word;
        r_nbytes   <= n_nbytes;
        r_last     <= n_last;
        r_k        <= n_k;
        r_hash_out <= n_hash_out;
        r_bucket   <= n_bucket;
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_cfg_ready    = (r_state == S_IDLE);
    assign o_valid        = (r_state == S_OUT);
    assign o_hash_value   = r_hash_out;
    assign o_bucket_index = r_bucket;

`ifndef NO_ASSERTIONS
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> (r_state == S_DIV))
        else $error("remainder unit finished outside the divide state");

    a_bucket_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_bucket_count != '0)) |-> ({1'b0, o_bucket_index} < r_bucket_count))
        else $error("bucket index not below bucket count");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_FIN_WB || $past(r_state) == S_DIV))
        else $error("result raised without finalize or divide");

    a_no_div_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !w_div_sts.busy)
        else $error("remainder unit busy while accepting requests");
`endif

endmodule

@@ dv/tb_murmur2_key_hash_bucket.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_murmur2_key_hash_bucket
// Streams keys into the MurmurHash2 bucket hasher and checks each finalized
// hash and bucket index against a cycle-free model kept in a small class.
// A short directed pass covers field extremes and the odd cases, then random
// keys run under several bucket counts and idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_murmur2_key_hash_bucket;

    import mh2b_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 48;
    localparam int SEG_ITEMS    = 250;

    typedef struct {
        logic [31:0]         hash;
        logic [C_BIDX_W-1:0] bucket;
    } hash_result_t;

    class key_hash_tracker;
        logic [31:0]         hash_acc;
        logic [C_BCNT_W-1:0] bucket_div;
        hash_result_t        expected_hashes[$];
        int                  mismatch_count;

        function new();
            hash_acc       = '0;
            bucket_div     = C_BCNT_RESET;
            mismatch_count = 0;
        endfunction

        function void set_buckets(logic [C_BCNT_W-1:0] count);
            bucket_div = count;
        endfunction

        function int pending();
            return expected_hashes.size();
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatch_count++;
        endtask

        // Advance the running hash by one accepted request; queue a result on last.
        function void note_request(logic [31:0] word, logic [2:0] nbytes, logic first,
                                   logic last, logic [15:0] klen);
            logic [31:0]  h;
            logic [31:0]  k;
            logic [31:0]  mask;
            logic [31:0]  f;
            logic [31:0]  rem;
            hash_result_t res;
            h = first ? (C_HASH_SEED ^ {16'h0, klen}) : hash_acc;
            if (nbytes >= 3'd4) begin
                k = word * C_HASH_MULT;
                k = k ^ (k >> C_WORD_SHIFT);
                k = k * C_HASH_MULT;
                h = h * C_HASH_MULT;
                h = h ^ k;
            end else if (nbytes != 3'd0) begin
                mask = (nbytes == 3'd1) ? 32'h0000_00ff :
                       (nbytes == 3'd2) ? 32'h0000_ffff : 32'h00ff_ffff;
                h = h ^ (word & mask);
                h = h * C_HASH_MULT;
            end
            hash_acc = h;
            if (last) begin
                f = h ^ (h >> C_FIN_SHIFT_A);
                f = f * C_HASH_MULT;
                f = f ^ (f >> C_FIN_SHIFT_B);
                rem = (bucket_div == '0) ? 32'h0 : f % {15'h0, bucket_div};
                res.hash   = f;
                res.bucket = rem[C_BIDX_W-1:0];
                expected_hashes.push_back(res);
            end
        endfunction

        task check_result(logic [31:0] hash, logic [C_BIDX_W-1:0] bucket);
            hash_result_t exp_res;
            if (expected_hashes.size() == 0) begin
                report_mismatch($sformatf("unexpected result hash=%08h bucket=%0d",
                                          hash, bucket));
                return;
            end
            exp_res = expected_hashes.pop_front();
            if (hash !== exp_res.hash)
                report_mismatch($sformatf("hash_value got %08h exp %08h",
                                          hash, exp_res.hash));
            if (bucket !== exp_res.bucket)
                report_mismatch($sformatf("bucket_index got %0d exp %0d",
                                          bucket, exp_res.bucket));
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [31:0]         i_key_word;
    logic [2:0]          i_valid_bytes;
    logic                i_first_word;
    logic                i_last_word;
    logic [15:0]         i_key_length;
    logic                o_valid;
    logic                i_ready;
    logic [31:0]         o_hash_value;
    logic [C_BIDX_W-1:0] o_bucket_index;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [C_BCNT_W-1:0] i_cfg_bucket_count;

    key_hash_tracker tracker;
    int              snd_idle_pct;
    int              rcv_idle_pct;
    int              items_sent;
    int              idle_cycles = 0;

    murmur2_key_hash_bucket dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_key_word         (i_key_word),
        .i_valid_bytes      (i_valid_bytes),
        .i_first_word       (i_first_word),
        .i_last_word        (i_last_word),
        .i_key_length       (i_key_length),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_hash_value       (o_hash_value),
        .o_bucket_index     (o_bucket_index),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_bucket_count (i_cfg_bucket_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Stall the result side at random; check whatever gets taken.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready)
                tracker.check_result(o_hash_value, o_bucket_index);
            @(negedge i_clk);
            i_ready = ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Abort when no channel moves anything for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Called right after a falling edge; returns right after one.
    task automatic send_request(logic [31:0] word, logic [2:0] nbytes, logic first,
                                logic last, logic [15:0] klen);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_key_word    = word;
        i_valid_bytes = nbytes;
        i_first_word  = first;
        i_last_word   = last;
        i_key_length  = klen;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_request(word, nbytes, first, last, klen);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Stream one key of nbytes bytes; drop last_word when close is 0.
    task automatic send_key(int unsigned nbytes, logic [15:0] klen, bit close);
        int unsigned n;
        int unsigned left;
        logic [2:0]  vb;
        n    = (nbytes + 3) / 4;
        left = nbytes;
        if (n == 0)
            n = 1;
        for (int i = 0; i < n; i++) begin
            vb   = (left >= 4) ? 3'd4 : left[2:0];
            left = left - vb;
            send_request($urandom, vb, i == 0, close && (i == n - 1), klen);
        end
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (tracker.pending() != 0)
            @(negedge i_clk);
        // hold for a request that produces no result and may still be in flight
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_buckets(logic [C_BCNT_W-1:0] count);
        wait_drained();
        i_cfg_valid        = 1'b1;
        i_cfg_bucket_count = count;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_buckets(count);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic run_random(int count);
        int          start;
        int          roll;
        int unsigned len;
        logic [15:0] klen;
        start = items_sent;
        while (items_sent - start < count) begin
            roll = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 16);
            klen = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(len);
            if (roll < 80) begin
                send_key(len, klen, 1'b1);
            end else if (roll < 90) begin
                send_request($urandom, 3'($urandom), 1'($urandom), 1'($urandom),
                             16'($urandom));
            end else begin
                // truncated key: no last word, next key restarts the hash
                send_key(len, klen, 1'b0);
            end
        end
    endtask

    initial begin
        logic [C_BCNT_W-1:0] settings[6];
        tracker            = new();
        items_sent         = 0;
        snd_idle_pct       = 37;
        rcv_idle_pct       = 73;
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_key_word         = '0;
        i_valid_bytes      = '0;
        i_first_word       = 1'b0;
        i_last_word        = 1'b0;
        i_key_length       = '0;
        i_cfg_valid        = 1'b0;
        i_cfg_bucket_count = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // continue from the zero hash left by reset
        send_request(32'hcafe_f00d, 3'd4, 1'b0, 1'b1, 16'h0000);
        send_request(32'h0000_0000, 3'd0, 1'b1, 1'b1, 16'h0000);
        send_request(32'hffff_ffff, 3'd4, 1'b1, 1'b1, 16'hffff);
        send_request(32'h0000_0000, 3'd4, 1'b1, 1'b1, 16'h0004);
        // tails with junk above the valid bytes
        send_request(32'hffff_ffff, 3'd1, 1'b1, 1'b1, 16'h0001);
        send_request(32'hffff_ffff, 3'd2, 1'b1, 1'b1, 16'h0002);
        send_request(32'hffff_ffff, 3'd3, 1'b1, 1'b1, 16'h0003);
        // oversized byte counts act as full words
        send_request(32'ha5a5_a5a5, 3'd5, 1'b1, 1'b1, 16'h0004);
        send_request(32'h5a5a_5a5a, 3'd6, 1'b1, 1'b1, 16'h0004);
        send_request(32'hffff_ffff, 3'd7, 1'b1, 1'b1, 16'h0004);
        // multi-word key with a short word in the middle
        send_request(32'h1234_5678, 3'd4, 1'b1, 1'b0, 16'h000d);
        send_request(32'h9abc_def0, 3'd2, 1'b0, 1'b0, 16'hffff);
        send_request(32'h5a5a_5a5a, 3'd4, 1'b0, 1'b0, 16'h0000);
        send_request(32'haaaa_aaaa, 3'd3, 1'b0, 1'b1, 16'haaaa);
        // no first word: keep hashing from the previous key
        send_request(32'hdead_beef, 3'd4, 1'b0, 1'b1, 16'h5555);
        send_request(32'h0000_0000, 3'd0, 1'b1, 1'b0, 16'haaaa);
        send_request(32'hffff_ffff, 3'd0, 1'b0, 1'b1, 16'h5555);
        send_request(32'hffff_ffff, 3'd0, 1'b1, 1'b1, 16'hffff);
        send_request(32'hc3c3_c3c3, 3'd3, 1'b0, 1'b0, 16'h0000);
        send_request(32'h0000_0001, 3'd1, 1'b0, 1'b1, 16'h0000);

        settings[0] = 17'd1;
        settings[1] = 17'd65536;
        settings[2] = 17'h1ffff;
        settings[3] = 17'd0;
        settings[4] = 17'($urandom_range(2, 65535));
        settings[5] = 17'($urandom_range(2, 131071));
        for (int s = 0; s < 6; s++) begin
            write_buckets(settings[s]);
            if (s == 2) begin
                snd_idle_pct = 73;
                rcv_idle_pct = 37;
            end else if (s == 4) begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            run_random(SEG_ITEMS);
        end

        wait_drained();
        if (tracker.pending() != 0)
            tracker.report_mismatch($sformatf("%0d results never arrived",
                                              tracker.pending()));
        if (tracker.mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ murmur2_key_hash_bucket.f @@
rtl/core/mh2b_pkg.sv
rtl/core/mh2b_mul.sv
rtl/core/mh2b_div.sv
rtl/core/murmur2_key_hash_bucket.sv
dv/tb_murmur2_key_hash_bucket.sv
